>>> src/line_to_led_matrix_index_assert.svh
// ----------------------------------------------------------------------------
// Line to LED matrix index: assertion macros
// Shared property forms for the assertions of the line walker.
// ----------------------------------------------------------------------------
`ifndef LINE_TO_LED_MATRIX_INDEX_ASSERT_SVH
`define LINE_TO_LED_MATRIX_INDEX_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LLMI_ASSERT_NOW(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |-> (cond_b)) \
    else $error("line walker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define LLMI_ASSERT_NEXT(label, cond_a, cond_b) \
  label: assert property (@(posedge clk) disable iff (rst) (cond_a) |=> (cond_b)) \
    else $error("line walker: next-cycle property failed");

`endif

>>> src/llmi_pkg.sv
// ----------------------------------------------------------------------------
// Line to LED matrix index package
// Payload types, register indexes and the microcode table of the line walker.
// ----------------------------------------------------------------------------
package llmi_pkg;

  localparam int MAX_DIM  = 64;
  localparam int COORD_W  = 6;
  localparam int DIM_W    = 7;
  localparam int INDEX_W  = 12;
  localparam int COLOR_W  = 24;
  localparam int ERR_W    = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH      = 3'd0,
    REG_HEIGHT     = 3'd1,
    REG_SERPENTINE = 3'd2,
    REG_ROTATED    = 3'd3,
    REG_FLIPPED    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0] pixel_color;
  } line_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] write_color;
    logic               write_valid;
    logic               last_point;
  } pixel_res_t;

  // Sequencer steps and jump conditions.
  typedef enum logic {
    STEP_IDLE = 1'b0,
    STEP_DRAW = 1'b1
  } step_t;

  typedef enum logic {
    COND_ACCEPT = 1'b0,
    COND_LAST   = 1'b1
  } cond_t;

  typedef struct packed {
    logic  take_req;
    logic  emit;
    cond_t cond;
    step_t target;
  } ucode_t;

  // Microcode table: one control word per step.
  function automatic ucode_t ucode_rom(step_t s);
    ucode_t cw;
    unique case (s)
      STEP_IDLE: cw = '{take_req: 1'b1, emit: 1'b0, cond: COND_ACCEPT, target: STEP_DRAW};
      STEP_DRAW: cw = '{take_req: 1'b0, emit: 1'b1, cond: COND_LAST,   target: STEP_IDLE};
      default:   cw = '{take_req: 1'b1, emit: 1'b0, cond: COND_ACCEPT, target: STEP_DRAW};
    endcase
    return cw;
  endfunction

endpackage

>>> src/line_to_led_matrix_index.sv
// ----------------------------------------------------------------------------
// Line to LED matrix index
// Walks a Bresenham line and gives the LED index of every point on it.
// ----------------------------------------------------------------------------
// A line request on req_data (start point, end point, color) is taken while
// req_valid and req_ready are both high. The block then gives one result per
// point of the line on pix_data, start point first, with last_point set on
// the end point. Points outside the configured matrix come out with
// write_valid clear and zero index and color.
// A request is taken in the load step; the draw step then registers its points
// in the output register. While the receiver takes results, one point leaves
// per cycle, so a request of N points (N is the larger coordinate distance plus
// one, at most 64) occupies the load step and then the draw step for N points.
// A stalled receiver holds the output register and the sequencer in place.
// req_ready is high only in the load step.
// Configuration writes (cfg_wr_en, cfg_index, cfg_data) take effect at once.
// The user must make them while no line is in flight; the block has no check.
// Synchronous reset empties the output, returns the sequencer to its load
// step and sets a 16 by 16 row-major matrix with no flip or serpentine order.
// ----------------------------------------------------------------------------
`include "line_to_led_matrix_index_assert.svh"

module line_to_led_matrix_index
  import llmi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  line_req_t            req_data,
  output logic                 pix_valid,
  input  logic                 pix_ready,
  output pixel_res_t           pix_data
);

  // Configuration registers.
  logic [DIM_W-1:0] matrix_width;
  logic [DIM_W-1:0] matrix_height;
  logic             serpentine_mode;
  logic             rotated_mode;
  logic             flipped_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_width    <= DIM_W'(16);
      matrix_height   <= DIM_W'(16);
      serpentine_mode <= 1'b0;
      rotated_mode    <= 1'b0;
      flipped_mode    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_WIDTH:      matrix_width    <= cfg_data;
        REG_HEIGHT:     matrix_height   <= cfg_data;
        REG_SERPENTINE: serpentine_mode <= cfg_data[0];
        REG_ROTATED:    rotated_mode    <= cfg_data[0];
        REG_FLIPPED:    flipped_mode    <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  // Sequencer.
  step_t  step;
  step_t  step_next;
  ucode_t cw;
  logic   accept;
  logic   out_free;
  logic   fire;
  logic   is_last;
  logic   advance;

  // Walker datapath registers.
  logic        [COORD_W-1:0] cur_x;
  logic        [COORD_W-1:0] cur_y;
  logic        [COORD_W-1:0] end_x;
  logic        [COORD_W-1:0] end_y;
  logic                      step_x_neg;
  logic                      step_y_neg;
  logic signed [ERR_W-1:0]   dx;
  logic signed [ERR_W-1:0]   dy;
  logic signed [ERR_W-1:0]   err;
  logic        [COLOR_W-1:0] color;

  always_comb begin
    cw        = ucode_rom(step);
    req_ready = cw.take_req;
    accept    = req_valid && cw.take_req;
    out_free  = !pix_valid || pix_ready;
    fire      = cw.emit && out_free;
    is_last   = (cur_x == end_x) && (cur_y == end_y);
    advance   = fire && !is_last;
    step_next = step;
    unique case (cw.cond)
      COND_ACCEPT: if (accept) step_next = cw.target;
      COND_LAST:   if (fire && is_last) step_next = cw.target;
      default:     step_next = step;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Load values of a new request.
  logic [COORD_W-1:0] abs_dx;
  logic [COORD_W-1:0] abs_dy;

  always_comb begin
    abs_dx = (req_data.end_x > req_data.start_x) ? req_data.end_x - req_data.start_x
                                                 : req_data.start_x - req_data.end_x;
    abs_dy = (req_data.end_y > req_data.start_y) ? req_data.end_y - req_data.start_y
                                                 : req_data.start_y - req_data.end_y;
  end

  // Bresenham step: the error term is compared as twice its value.
  logic signed [ERR_W:0] e2;
  logic signed [ERR_W:0] dx_w;
  logic signed [ERR_W:0] dy_w;
  logic                  move_x;
  logic                  move_y;
  logic signed [ERR_W:0] err_sum;

  always_comb begin
    e2      = {err, 1'b0};
    dx_w    = (ERR_W+1)'(dx);
    dy_w    = (ERR_W+1)'(dy);
    move_x  = e2 > dy_w;
    move_y  = e2 < dx_w;
    err_sum = (ERR_W+1)'(err) + (move_x ? dy_w : '0) + (move_y ? dx_w : '0);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_x      <= req_data.start_x;
      cur_y      <= req_data.start_y;
      end_x      <= req_data.end_x;
      end_y      <= req_data.end_y;
      step_x_neg <= !(req_data.start_x < req_data.end_x);
      step_y_neg <= !(req_data.start_y < req_data.end_y);
      dx         <= ERR_W'(abs_dx);
      dy         <= -ERR_W'(abs_dy);
      err        <= ERR_W'(abs_dx) - ERR_W'(abs_dy);
      color      <= req_data.pixel_color;
    end else if (advance) begin
      if (move_x) cur_x <= step_x_neg ? cur_x - 1'b1 : cur_x + 1'b1;
      if (move_y) cur_y <= step_y_neg ? cur_y - 1'b1 : cur_y + 1'b1;
      err <= ERR_W'(err_sum);
    end
  end

  // Point to LED index mapping.
  logic [DIM_W-1:0]       w_eff;
  logic [DIM_W-1:0]       h_eff;
  logic                   in_matrix;
  logic [COORD_W-1:0]     uy;
  logic [COORD_W-1:0]     major;
  logic [COORD_W-1:0]     minor;
  logic [DIM_W-1:0]       span;
  logic [COORD_W-1:0]     minor_ord;
  logic [COORD_W+DIM_W-1:0] lin;

  always_comb begin
    w_eff     = (matrix_width  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : matrix_width;
    h_eff     = (matrix_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : matrix_height;
    in_matrix = ({1'b0, cur_x} < w_eff) && ({1'b0, cur_y} < h_eff);
    // Only used when the point is inside, so h - 1 - y stays in range.
    uy     = flipped_mode ? COORD_W'(h_eff - DIM_W'(1) - {1'b0, cur_y}) : cur_y;
    if (rotated_mode) begin
      major = cur_x;
      minor = uy;
      span  = h_eff;
    end else begin
      major = uy;
      minor = cur_x;
      span  = w_eff;
    end
    minor_ord = (serpentine_mode && major[0])
                ? COORD_W'(span - DIM_W'(1) - {1'b0, minor}) : minor;
    lin = (COORD_W+DIM_W)'(major) * (COORD_W+DIM_W)'(span)
          + (COORD_W+DIM_W)'(minor_ord);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (fire) begin
      pix_valid <= 1'b1;
    end else if (pix_ready) begin
      pix_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pix_data.pixel_index <= in_matrix ? lin[INDEX_W-1:0] : '0;
      pix_data.write_color <= in_matrix ? color : '0;
      pix_data.write_valid <= in_matrix;
      pix_data.last_point  <= is_last;
    end
  end

  // Assertions.
  `LLMI_ASSERT_NEXT(a_req_starts_draw, req_valid && req_ready, step == STEP_DRAW)
  `LLMI_ASSERT_NOW(a_no_req_while_drawing, step == STEP_DRAW, !req_ready)
  `LLMI_ASSERT_NEXT(a_last_returns_idle, fire && is_last, step == STEP_IDLE)
  `LLMI_ASSERT_NOW(a_unwritten_is_zero, pix_valid && !pix_data.write_valid, pix_data.pixel_index == '0 && pix_data.write_color == '0)

endmodule
